FILE: src/iz_pkg.sv
// package: shared types, constants and codes for the intrusion zone monitor
`timescale 1ns / 1ps

package iz_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int MASK_W      = 8;
    localparam int PIN_W       = 8;
    localparam int TYPES_W     = 16;
    localparam int CNT_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX         = '1;
    localparam logic [CNT_W-1:0] WINDOW_RESET    = 12'd60;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 12'd10;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_TYPES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMS_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_FLAGS  = 3'd6;

    localparam int SOUND_EXIT_BIT  = 0;
    localparam int SOUND_ENTER_BIT = 1;
    localparam int SOUND_LOOP_BIT  = 2;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_ARMED = 2'd1,
        CMD_TOGGLE    = 2'd2,
        CMD_SET_ALARM = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        TYPE_MICROWAVE = 2'd0,
        TYPE_PIR       = 2'd1,
        TYPE_REED      = 2'd2
    } sensor_type_t;

    typedef enum logic [1:0] {
        CHIME_NONE  = 2'd0,
        CHIME_EXIT  = 2'd1,
        CHIME_ENTER = 2'd2
    } chime_t;

    typedef enum logic [1:0] {
        SOUND_KEEP  = 2'd0,
        SOUND_START = 2'd1,
        SOUND_STOP  = 2'd2
    } sound_t;

    typedef struct packed {
        logic             tick;
        logic             clear;
        logic             close;
        logic [CNT_W-1:0] threshold;
    } lane_ctrl_t;

    typedef struct packed {
        logic newly;
        logic detected;
    } lane_stat_t;

    typedef struct packed {
        logic [MASK_W-1:0] new_mask;
        logic [MASK_W-1:0] sms_mask;
        logic [MASK_W-1:0] msg_mask;
        logic              alarm_hit;
    } merge_res_t;

    typedef struct packed {
        logic              pad;
        sound_t            alarm_sound;
        chime_t            chime;
        logic [MASK_W-1:0] message_mask;
        logic [MASK_W-1:0] sms_mask;
        logic [MASK_W-1:0] new_detect_mask;
        logic              status_changed;
        logic              alarm_on;
        logic              armed;
    } result_t;

endpackage

FILE: src/intrusion_zone_monitor.sv
// top level: config registers, window timer, arm/alarm control, lanes and output skid
`timescale 1ns / 1ps

// channel  | direction | payload
// s_       | in        | tuser[1:0] command; tdata[7:0] pin_levels, [8] set_value
// m_       | out       | tdata[0] armed .. [30:29] alarm_sound, see port comment
// cfg_     | in        | cfg_index register number, cfg_data value
//
// one transaction per clock while s_tready is high: the lanes and the arm/alarm logic
// update in the cycle of acceptance and the result is registered
// an output register plus a skid stage keep s_tready high while one result waits
// aresetn resets all but the output data; config takes effect on the next transaction

module intrusion_zone_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [iz_pkg::IN_DATA_W-1:0]     s_tdata,   // pin_levels, set_value
    input  logic [1:0]                       s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // armed, alarm_on, status_changed, new_detect_mask, sms_mask,
    // message_mask, chime, alarm_sound
    output logic [iz_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iz_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [iz_pkg::TYPES_W-1:0] sensor_types_reg;
    logic [iz_pkg::MASK_W-1:0]  alarm_mask_reg;
    logic [iz_pkg::MASK_W-1:0]  sms_mask_reg;
    logic [iz_pkg::MASK_W-1:0]  msg_mask_reg;
    logic [iz_pkg::CNT_W-1:0]   window_reg;
    logic [iz_pkg::CNT_W-1:0]   threshold_reg;
    logic [2:0]                 sound_flags_reg;

    logic                       armed_reg;
    logic                       armed_next;
    logic                       alarm_reg;
    logic                       alarm_next;
    logic [iz_pkg::CNT_W-1:0]   timer_reg;
    logic [iz_pkg::CNT_W-1:0]   timer_next;
    logic [iz_pkg::CNT_W:0]     timer_inc;

    iz_pkg::result_t            out_reg;
    iz_pkg::result_t            out_next;
    logic                       out_valid_reg;
    iz_pkg::result_t            skid_reg;
    logic                       skid_valid_reg;

    logic                       cfg_we;
    logic                       accept;
    iz_pkg::command_t           cmd;
    logic [iz_pkg::PIN_W-1:0]   pins;
    logic                       set_value;
    logic                       target;
    logic                       change;
    logic                       clear_sensors;
    logic                       is_tick;

    iz_pkg::lane_ctrl_t               lane_ctrl;
    iz_pkg::lane_stat_t               lane_stat [iz_pkg::NUM_SENSORS];
    logic [iz_pkg::NUM_SENSORS-1:0]   newly;
    logic [iz_pkg::NUM_SENSORS-1:0]   det_vec;
    iz_pkg::merge_res_t               merge_res;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = iz_pkg::command_t'(s_tuser);
    assign pins      = s_tdata[iz_pkg::PIN_W-1:0];
    assign set_value = s_tdata[iz_pkg::PIN_W];
    assign is_tick   = accept && cmd == iz_pkg::CMD_TICK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_types_reg <= '0;
            alarm_mask_reg   <= '0;
            sms_mask_reg     <= '0;
            msg_mask_reg     <= '0;
            window_reg       <= iz_pkg::WINDOW_RESET;
            threshold_reg    <= iz_pkg::THRESHOLD_RESET;
            sound_flags_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                iz_pkg::REG_SENSOR_TYPES: sensor_types_reg <= cfg_data;
                iz_pkg::REG_ALARM_MASK:   alarm_mask_reg   <= cfg_data[iz_pkg::MASK_W-1:0];
                iz_pkg::REG_SMS_MASK:     sms_mask_reg     <= cfg_data[iz_pkg::MASK_W-1:0];
                iz_pkg::REG_MSG_MASK:     msg_mask_reg     <= cfg_data[iz_pkg::MASK_W-1:0];
                iz_pkg::REG_WINDOW:       window_reg       <= cfg_data[iz_pkg::CNT_W-1:0];
                iz_pkg::REG_THRESHOLD:    threshold_reg    <= cfg_data[iz_pkg::CNT_W-1:0];
                iz_pkg::REG_SOUND_FLAGS:  sound_flags_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // window timer
    assign timer_inc  = {1'b0, timer_reg} + 1'b1;
    assign timer_next = (timer_inc > {1'b0, window_reg}) ? '0 : timer_inc[iz_pkg::CNT_W-1:0];

    // arm and alarm control
    always_comb begin
        target        = armed_reg;
        change        = 1'b0;
        clear_sensors = 1'b0;
        armed_next    = armed_reg;
        alarm_next    = alarm_reg;
        out_next      = '0;
        case (cmd)
            iz_pkg::CMD_TICK: begin
                out_next.new_detect_mask = merge_res.new_mask;
                out_next.sms_mask        = merge_res.sms_mask;
                out_next.message_mask    = merge_res.msg_mask;
                if (merge_res.alarm_hit && !alarm_reg) begin
                    alarm_next = 1'b1;
                    if (sound_flags_reg[iz_pkg::SOUND_LOOP_BIT]) begin
                        out_next.alarm_sound = iz_pkg::SOUND_START;
                    end
                end
            end
            iz_pkg::CMD_SET_ARMED, iz_pkg::CMD_TOGGLE: begin
                target = (cmd == iz_pkg::CMD_SET_ARMED) ? set_value : !armed_reg;
                change = target != armed_reg;
                if (change) begin
                    armed_next              = target;
                    clear_sensors           = 1'b1;
                    out_next.status_changed = 1'b1;
                    if (!target) begin
                        alarm_next = 1'b0;
                        if (sound_flags_reg[iz_pkg::SOUND_LOOP_BIT]) begin
                            out_next.alarm_sound = iz_pkg::SOUND_STOP;
                        end
                    end
                    if (target && sound_flags_reg[iz_pkg::SOUND_EXIT_BIT]) begin
                        out_next.chime = iz_pkg::CHIME_EXIT;
                    end else if (!target && sound_flags_reg[iz_pkg::SOUND_ENTER_BIT]) begin
                        out_next.chime = iz_pkg::CHIME_ENTER;
                    end
                end
            end
            default: begin
                alarm_next = set_value;
                if (sound_flags_reg[iz_pkg::SOUND_LOOP_BIT]) begin
                    out_next.alarm_sound = set_value ? iz_pkg::SOUND_START : iz_pkg::SOUND_STOP;
                end
            end
        endcase
        out_next.armed    = armed_next;
        out_next.alarm_on = alarm_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            alarm_reg <= 1'b0;
            timer_reg <= '0;
        end else if (accept) begin
            armed_reg <= armed_next;
            alarm_reg <= alarm_next;
            if (cmd == iz_pkg::CMD_TICK) begin
                timer_reg <= timer_next;
            end
        end
    end

    // sensor lanes
    assign lane_ctrl.tick      = is_tick;
    assign lane_ctrl.clear     = accept && clear_sensors;
    assign lane_ctrl.close     = timer_next == window_reg;
    assign lane_ctrl.threshold = threshold_reg;

    for (genvar i = 0; i < iz_pkg::NUM_SENSORS; i++) begin : g_lane
        logic [1:0] lane_type;
        logic       lane_level;

        if (2 * i + 1 < iz_pkg::TYPES_W) begin : g_type
            assign lane_type = sensor_types_reg[2*i+1:2*i];
        end else begin : g_no_type
            assign lane_type = iz_pkg::TYPE_MICROWAVE;
        end
        if (i < iz_pkg::PIN_W) begin : g_pin
            assign lane_level = pins[i];
        end else begin : g_no_pin
            assign lane_level = 1'b0;
        end

        iz_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (lane_ctrl),
            .sensor_type (lane_type),
            .level       (lane_level),
            .stat        (lane_stat[i])
        );

        assign newly[i]   = lane_stat[i].newly;
        assign det_vec[i] = lane_stat[i].detected;
    end

    iz_merge u_merge (
        .newly      (newly),
        .armed      (armed_reg),
        .alarm_mask (alarm_mask_reg),
        .sms_mask   (sms_mask_reg),
        .msg_mask   (msg_mask_reg),
        .res        (merge_res)
    );

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= out_next;
            end
        end else if (accept) begin
            skid_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_clear_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && clear_sensors |=> det_vec == '0)
        else $error("detection flags survive an armed status change");

    a_timer_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        is_tick && !cfg_we |=> timer_reg <= window_reg)
        else $error("window timer beyond window length after a tick");

    a_disarm_clears_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && clear_sensors && !armed_next |=> !alarm_reg && !armed_reg)
        else $error("alarm latch still set after disarming");

endmodule

FILE: src/iz_lane.sv
// per-sensor lane: sample counter, window close and detection flag
`timescale 1ns / 1ps

module iz_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  iz_pkg::lane_ctrl_t ctrl,
    input  logic [1:0]         sensor_type,
    input  logic               level,
    output iz_pkg::lane_stat_t stat
);

    logic [iz_pkg::CNT_W-1:0] count_reg;
    logic [iz_pkg::CNT_W-1:0] count_next;
    logic                     det_reg;
    logic                     det_next;
    logic                     active;
    logic                     reed_hit;
    logic [iz_pkg::CNT_W-1:0] count_inc;
    logic                     hit;

    always_comb begin
        active   = 1'b0;
        reed_hit = 1'b0;
        case (sensor_type)
            iz_pkg::TYPE_MICROWAVE: active   = ~level;
            iz_pkg::TYPE_PIR:       active   = level;
            iz_pkg::TYPE_REED:      reed_hit = ~level;
            default: begin
                active   = 1'b0;
                reed_hit = 1'b0;
            end
        endcase
    end

    assign count_inc = (active && count_reg != iz_pkg::CNT_MAX) ?
                       count_reg + 1'b1 : count_reg;
    assign hit = reed_hit || (ctrl.close && count_inc >= ctrl.threshold);

    always_comb begin
        count_next = count_reg;
        det_next   = det_reg;
        if (ctrl.clear) begin
            count_next = '0;
            det_next   = 1'b0;
        end else if (ctrl.tick && !det_reg) begin
            count_next = ctrl.close ? '0 : count_inc;
            det_next   = hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            det_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            det_reg   <= det_next;
        end
    end

    assign stat.newly    = ctrl.tick && !ctrl.clear && !det_reg && hit;
    assign stat.detected = det_reg;

endmodule

FILE: src/iz_merge.sv
// merging stage: gathers new lane detections, while armed, into report masks and alarm trigger
`timescale 1ns / 1ps

module iz_merge (
    input  logic [iz_pkg::NUM_SENSORS-1:0] newly,
    input  logic                           armed,
    input  logic [iz_pkg::MASK_W-1:0]      alarm_mask,
    input  logic [iz_pkg::MASK_W-1:0]      sms_mask,
    input  logic [iz_pkg::MASK_W-1:0]      msg_mask,
    output iz_pkg::merge_res_t             res
);

    logic [iz_pkg::MASK_W-1:0] lane_bits;
    logic [iz_pkg::MASK_W-1:0] reported;

    for (genvar j = 0; j < iz_pkg::MASK_W; j++) begin : g_bit
        if (j < iz_pkg::NUM_SENSORS) begin : g_lane
            assign lane_bits[j] = newly[j];
        end else begin : g_none
            assign lane_bits[j] = 1'b0;
        end
    end

    assign reported      = armed ? lane_bits : '0;
    assign res.new_mask  = reported;
    assign res.sms_mask  = reported & sms_mask;
    assign res.msg_mask  = reported & msg_mask;
    assign res.alarm_hit = |(reported & alarm_mask);

endmodule
